// File: src/sdwq_pkg.sv
// ----------------------------------------------------------------------------
// sdwq_pkg
// Shared types and constants of the sorted deadline wait queue.
// ----------------------------------------------------------------------------
package sdwq_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int TIME_BITS_DEF   = 32;
  localparam int HANDLE_W        = 16;
  localparam int IN_TIME_W       = 32;
  localparam int DELAY_W         = 32;
  localparam int MIN_DELAY_W     = 16;
  localparam logic [MIN_DELAY_W-1:0] MIN_DELAY_RESET = 16'd100;
  localparam logic [DELAY_W-1:0]     DELAY_MAX       = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_WAKE  = 2'd1,
    OP_FLUSH = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_t;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic insert;
    logic pop;
  } sdwq_ctrl_t;

endpackage

// File: src/sdwq_cell.sv
// ----------------------------------------------------------------------------
// sdwq_cell
// One slot of the sorted chain: holds a deadline and a handle, takes the new
// entry or its left neighbor on insert, its right neighbor on pop.
// ----------------------------------------------------------------------------
module sdwq_cell
  import sdwq_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sdwq_ctrl_t           ctrl,
  input  logic [TIME_BITS-1:0] new_deadline,
  input  logic [HANDLE_W-1:0]  new_handle,
  input  logic                 left_valid,
  input  logic [TIME_BITS-1:0] left_deadline,
  input  logic [HANDLE_W-1:0]  left_handle,
  input  logic                 left_ins,
  input  logic                 right_valid,
  input  logic [TIME_BITS-1:0] right_deadline,
  input  logic [HANDLE_W-1:0]  right_handle,
  output logic                 valid,
  output logic [TIME_BITS-1:0] deadline,
  output logic [HANDLE_W-1:0]  handle,
  output logic                 ins
);

  // The new entry belongs at or before this slot
  assign ins = !valid || (deadline > new_deadline);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.pop) begin
      valid <= right_valid;
    end else if (ctrl.insert && ins) begin
      valid <= left_ins ? left_valid : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      deadline <= right_deadline;
      handle   <= right_handle;
    end else if (ctrl.insert && ins) begin
      if (left_ins) begin
        deadline <= left_deadline;
        handle   <= left_handle;
      end else begin
        deadline <= new_deadline;
        handle   <= new_handle;
      end
    end
  end

endmodule

// File: src/sdwq_delay.sv
// ----------------------------------------------------------------------------
// sdwq_delay
// Timer delay: deadline minus now, zero when passed, raised to min_delay,
// saturated to 32 bits.
// ----------------------------------------------------------------------------
module sdwq_delay
  import sdwq_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic [TIME_BITS-1:0]   when_t,
  input  logic [TIME_BITS-1:0]   now_t,
  input  logic [MIN_DELAY_W-1:0] min_delay,
  output logic [DELAY_W-1:0]     delay
);

  localparam int DW = (TIME_BITS > DELAY_W) ? TIME_BITS : DELAY_W;

  logic [TIME_BITS-1:0] diff;
  logic [DW-1:0]        d_ext;

  always_comb begin
    diff  = (when_t > now_t) ? (when_t - now_t) : '0;
    d_ext = DW'(diff);
    if (d_ext < DW'(min_delay)) begin
      d_ext = DW'(min_delay);
    end
    if (d_ext > DW'(DELAY_MAX)) begin
      d_ext = DW'(DELAY_MAX);
    end
    delay = d_ext[DELAY_W-1:0];
  end

endmodule

// File: src/sorted_deadline_wait_queue.sv
// ----------------------------------------------------------------------------
// sorted_deadline_wait_queue
// Waiters kept sorted by deadline in a chain of cells; add, wakeup, flush.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  s_*     | s_tvalid/s_tready  | tuser op, tdata handle|deadline|now
//  m_*     | m_tvalid/m_tready  | tuser flags, tdata handle|delay, tlast
//  cfg_*   | cfg_valid/cfg_ready| cfg_data min_delay
//
//  One item at a time: the word is registered in IDLE, then one result per
//  cycle in BUSY while m_tready does not stall it. Add gives one result;
//  wakeup or flush pops the head cell once a cycle, one result per pop.
//  A stalled m_tready holds the chain. Synchronous reset empties the
//  chain and loads min_delay with 100; config is always ready.
// ----------------------------------------------------------------------------
module sorted_deadline_wait_queue
  import sdwq_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [1:0]             s_tuser,   // op
  input  logic [79:0]            s_tdata,   // handle[15:0], deadline[47:16], now[79:48]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [2:0]             m_tuser,   // woken_valid, timer_set, full_error
  output logic [47:0]            m_tdata,   // woken_handle[15:0], timer_delay[47:16]
  output logic                   m_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [MIN_DELAY_W-1:0] cfg_data
);

  state_t state, state_next;
  sdwq_ctrl_t ctrl;

  op_t                  op_q;
  logic [HANDLE_W-1:0]  handle_q;
  logic [TIME_BITS-1:0] deadline_q;
  logic [TIME_BITS-1:0] now_q;
  logic [MIN_DELAY_W-1:0] min_delay;

  logic                 valid_vec [DEPTH];
  logic [TIME_BITS-1:0] dl_vec    [DEPTH];
  logic [HANDLE_W-1:0]  hd_vec    [DEPTH];
  logic                 ins_vec   [DEPTH];
  logic [DEPTH-1:0]     valid_bits;

  logic                 out_free;
  logic                 emit;
  logic [2:0]           tuser_next;
  logic [47:0]          tdata_next;
  logic                 tlast_next;
  logic [TIME_BITS-1:0] delay_when;
  logic [DELAY_W-1:0]   delay;
  logic                 head_due;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_delay <= MIN_DELAY_RESET;
    end else if (cfg_valid) begin
      min_delay <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_q       <= op_t'(s_tuser);
      handle_q   <= s_tdata[15:0];
      deadline_q <= TIME_BITS'(s_tdata[47:16]);
      now_q      <= TIME_BITS'(s_tdata[79:48]);
    end
  end

  // Chain of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 l_valid, r_valid, l_ins;
    logic [TIME_BITS-1:0] l_dl, r_dl;
    logic [HANDLE_W-1:0]  l_hd, r_hd;

    if (i == 0) begin : g_left_end
      assign l_valid = 1'b0;
      assign l_dl    = '0;
      assign l_hd    = '0;
      assign l_ins   = 1'b0;
    end else begin : g_left
      assign l_valid = valid_vec[i-1];
      assign l_dl    = dl_vec[i-1];
      assign l_hd    = hd_vec[i-1];
      assign l_ins   = ins_vec[i-1];
    end

    if (i == DEPTH - 1) begin : g_right_end
      assign r_valid = 1'b0;
      assign r_dl    = '0;
      assign r_hd    = '0;
    end else begin : g_right
      assign r_valid = valid_vec[i+1];
      assign r_dl    = dl_vec[i+1];
      assign r_hd    = hd_vec[i+1];
    end

    sdwq_cell #(.TIME_BITS(TIME_BITS)) u_cell (
      .clk            (clk),
      .rst            (rst),
      .ctrl           (ctrl),
      .new_deadline   (deadline_q),
      .new_handle     (handle_q),
      .left_valid     (l_valid),
      .left_deadline  (l_dl),
      .left_handle    (l_hd),
      .left_ins       (l_ins),
      .right_valid    (r_valid),
      .right_deadline (r_dl),
      .right_handle   (r_hd),
      .valid          (valid_vec[i]),
      .deadline       (dl_vec[i]),
      .handle         (hd_vec[i]),
      .ins            (ins_vec[i])
    );

    assign valid_bits[i] = valid_vec[i];
  end

  assign delay_when = (op_q == OP_ADD) ? deadline_q : dl_vec[0];
  assign head_due   = valid_vec[0] && (dl_vec[0] <= now_q);

  sdwq_delay #(.TIME_BITS(TIME_BITS)) u_delay (
    .when_t    (delay_when),
    .now_t     (now_q),
    .min_delay (min_delay),
    .delay     (delay)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    emit       = 1'b0;
    tuser_next = '0;
    tdata_next = '0;
    tlast_next = 1'b1;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
          unique case (op_q)
            OP_ADD: begin
              if (valid_vec[DEPTH-1]) begin
                tuser_next[2] = 1'b1;
              end else begin
                ctrl.insert = 1'b1;
                if (ins_vec[0]) begin
                  tuser_next[1]      = 1'b1;
                  tdata_next[47:16]  = delay;
                end
              end
            end
            OP_WAKE: begin
              if (head_due) begin
                ctrl.pop          = 1'b1;
                tuser_next[0]     = 1'b1;
                tdata_next[15:0]  = hd_vec[0];
                tlast_next        = !valid_vec[1];
                if (valid_vec[1]) begin
                  state_next = ST_BUSY;
                end
              end else if (valid_vec[0]) begin
                tuser_next[1]     = 1'b1;
                tdata_next[47:16] = delay;
              end
            end
            OP_FLUSH: begin
              if (valid_vec[0]) begin
                ctrl.pop         = 1'b1;
                tuser_next[0]    = 1'b1;
                tdata_next[15:0] = hd_vec[0];
                tlast_next       = !valid_vec[1];
                if (valid_vec[1]) begin
                  state_next = ST_BUSY;
                end
              end
            end
            default: begin
              tlast_next = 1'b1;
            end
          endcase
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tuser <= tuser_next;
      m_tdata <= tdata_next;
      m_tlast <= tlast_next;
    end
  end

  // Valid cells always form a run starting at the head
  assert property (@(posedge clk) disable iff (rst)
    ((valid_bits >> 1) & ~valid_bits) == '0)
    else $error("gap in valid cells");

  assert property (@(posedge clk) disable iff (rst)
    !(ctrl.insert && ctrl.pop))
    else $error("insert and pop in the same cycle");

  assert property (@(posedge clk) disable iff (rst)
    ctrl.pop |-> valid_vec[0])
    else $error("pop from empty queue");

  assert property (@(posedge clk) disable iff (rst)
    ctrl.insert |=> valid_vec[0])
    else $error("insert left the head empty");

endmodule
